FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/sdfd_pkg.sv
`default_nettype none

package sdfd_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_SKIP  = 4'b0010,
        MODE_INSTR = 4'b0100,
        MODE_DATA  = 4'b1000
    } t_mode;

    typedef enum logic [1:0] {
        TGT_DISCARD = 2'd0,
        TGT_LOW     = 2'd1,
        TGT_HIGH    = 2'd2
    } t_target;

    typedef struct packed {
        logic emit;
        logic mapped;
    } t_frame_stat;

    localparam logic [7:0] INSTR_LOW_NIB  = 8'h0A;
    localparam logic [7:0] INSTR_HIGH_NIB = 8'h1A;
    localparam logic [6:0] INSTR_BITS     = 7'd8;
    localparam logic [6:0] DISCARD_BITS   = 7'd44;

    localparam int PIN_CLK  = 0;
    localparam int PIN_DATA = 1;
    localparam int PIN_INS  = 2;
    localparam int PIN_SYNC = 3;
    localparam int PIN_PWR  = 4;

    function automatic logic [15:0] glyph(input logic [5:0] c);
        logic [15:0] g;
        case (c)
            6'd0:  g = 16'h507F;  6'd1:  g = 16'h44CF;  6'd2:  g = 16'h153F;
            6'd3:  g = 16'h00F3;  6'd4:  g = 16'h113F;  6'd5:  g = 16'h40F3;
            6'd6:  g = 16'h40C3;  6'd7:  g = 16'h04FB;  6'd8:  g = 16'h44CC;
            6'd9:  g = 16'h1133;  6'd10: g = 16'h007C;  6'd11: g = 16'h4AC0;
            6'd12: g = 16'h00F0;  6'd13: g = 16'h82CC;  6'd14: g = 16'h88CC;
            6'd15: g = 16'h00FF;  6'd16: g = 16'h44C7;  6'd17: g = 16'h08FF;
            6'd18: g = 16'h4CC7;  6'd19: g = 16'h44BB;  6'd20: g = 16'h1103;
            6'd21: g = 16'h00FC;  6'd22: g = 16'h22C0;  6'd23: g = 16'h28CC;
            6'd24: g = 16'hAA00;  6'd25: g = 16'h9200;  6'd26: g = 16'h2233;
            6'd27: g = 16'h00E1;  6'd28: g = 16'h8800;  6'd29: g = 16'h001E;
            6'd30: g = 16'h2800;  6'd31: g = 16'h0030;  6'd32: g = 16'h0000;
            6'd33: g = 16'h8121;  6'd34: g = 16'h0180;  6'd35: g = 16'h553C;
            6'd36: g = 16'h55BB;  6'd37: g = 16'h7799;  6'd38: g = 16'hC979;
            6'd39: g = 16'h0200;  6'd40: g = 16'h0A00;  6'd41: g = 16'hA050;
            6'd42: g = 16'hFF00;  6'd43: g = 16'h5500;  6'd44: g = 16'h0000;
            6'd45: g = 16'h4400;  6'd46: g = 16'h0000;  6'd47: g = 16'h2200;
            6'd48: g = 16'h22FF;  6'd49: g = 16'h1100;  6'd50: g = 16'h4477;
            6'd51: g = 16'h443F;  6'd52: g = 16'h448C;  6'd53: g = 16'h44BB;
            6'd54: g = 16'h44FB;  6'd55: g = 16'h000F;  6'd56: g = 16'h44FF;
            6'd57: g = 16'h44BF;  6'd58: g = 16'hFFFF;  6'd59: g = 16'h2001;
            6'd60: g = 16'h2230;  6'd61: g = 16'h4430;  6'd62: g = 16'h8830;
            default: g = 16'h1407;
        endcase
        return g;
    endfunction

    function automatic logic [17:0] swap_segments(input logic [17:0] s);
        return {s[17:16], s[11], s[9], s[15], s[13], s[12], s[8], s[10], s[14], s[7:0]};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sdfd_frame.sv
`default_nettype none

module sdfd_frame #(
    parameter int DIGITS          = 12,
    parameter int DATA_FRAME_BITS = 100,
    parameter int IW              = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [4:0]           i_pins,
    input  wire logic [IW-1:0]        i_rd_idx,
    output sdfd_pkg::t_frame_stat     o_stat,
    output logic [7:0]                o_rd_char
);
    import sdfd_pkg::*;

    localparam logic [6:0] DATA_BITS = 7'(DATA_FRAME_BITS);

    logic        r_prev_clk, n_prev_clk;
    t_mode       r_mode, n_mode;
    t_target     r_target, n_target;
    logic [6:0]  r_count, n_count;
    logic [6:0]  r_wanted, n_wanted;
    logic [63:0] r_buf, n_buf;
    logic [7:0]  r_chars [DIGITS];
    logic [7:0]  n_chars [DIGITS];
    logic        r_mapped, n_mapped;

    logic        w_rising;
    logic        w_sync;
    logic        w_bit;
    logic [63:0] w_buf_or;
    logic [6:0]  w_count_inc;

    assign w_rising    = i_accept && i_pins[PIN_CLK] && !r_prev_clk;
    assign w_sync      = i_pins[PIN_SYNC];
    assign w_bit       = (r_mode == MODE_INSTR) ? i_pins[PIN_INS] : i_pins[PIN_DATA];
    assign w_buf_or    = r_count[6] ? r_buf : (r_buf | (64'(w_bit) << r_count[5:0]));
    assign w_count_inc = r_count + 7'd1;

    assign o_stat.emit   = w_rising && !i_pins[PIN_PWR];
    assign o_stat.mapped = r_mapped;
    assign o_rd_char     = r_chars[i_rd_idx];

    always_comb begin
        n_prev_clk = i_accept ? i_pins[PIN_CLK] : r_prev_clk;
        n_mode     = r_mode;
        n_target   = r_target;
        n_count    = r_count;
        n_wanted   = r_wanted;
        n_buf      = r_buf;
        n_chars    = r_chars;
        n_mapped   = r_mapped;
        if (w_rising) begin
            if (!i_pins[PIN_PWR]) begin
                n_mode   = MODE_IDLE;
                n_target = TGT_DISCARD;
                n_count  = '0;
                n_buf    = '0;
            end else begin
                case (r_mode)
                    MODE_IDLE: begin
                        n_wanted = INSTR_BITS;
                        n_mode   = MODE_SKIP;
                    end
                    MODE_SKIP: begin
                        n_count = '0;
                        n_buf   = '0;
                        if (w_sync) begin
                            n_mode   = MODE_INSTR;
                            n_wanted = INSTR_BITS;
                        end else begin
                            n_mode = MODE_DATA;
                        end
                    end
                    MODE_INSTR: begin
                        if (!w_sync) begin
                            n_mode  = MODE_SKIP;
                            n_count = '0;
                            n_buf   = '0;
                        end else if (w_count_inc != r_wanted) begin
                            n_count = w_count_inc;
                            n_buf   = w_buf_or;
                        end else begin
                            n_count = '0;
                            n_buf   = '0;
                            if (w_buf_or[7:0] == INSTR_LOW_NIB) begin
                                n_wanted = DATA_BITS;
                                n_target = TGT_LOW;
                            end else if (w_buf_or[7:0] == INSTR_HIGH_NIB) begin
                                n_wanted = DATA_BITS;
                                n_target = TGT_HIGH;
                            end else begin
                                n_wanted = DISCARD_BITS;
                                n_target = TGT_DISCARD;
                            end
                        end
                    end
                    default: begin
                        if (w_sync) begin
                            n_mode  = MODE_SKIP;
                            n_count = '0;
                            n_buf   = '0;
                        end else if (w_count_inc != r_wanted) begin
                            n_count = w_count_inc;
                            n_buf   = w_buf_or;
                        end else begin
                            n_count = '0;
                            n_buf   = '0;
                            if (r_target == TGT_LOW || r_target == TGT_HIGH) begin
                                n_mapped = 1'b1;
                                for (int i = 0; i < DIGITS; i++) begin
                                    if (r_target == TGT_HIGH) begin
                                        n_chars[i][7:4] = w_buf_or[4*(DIGITS-1-i) +: 4];
                                    end else begin
                                        n_chars[i][3:0] = w_buf_or[4*(DIGITS-1-i) +: 4];
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clk <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_target   <= TGT_DISCARD;
            r_count    <= '0;
            r_wanted   <= '0;
            r_buf      <= '0;
            r_mapped   <= 1'b0;
            for (int i = 0; i < DIGITS; i++) begin
                r_chars[i] <= '0;
            end
        end else begin
            r_prev_clk <= n_prev_clk;
            r_mode     <= n_mode;
            r_target   <= n_target;
            r_count    <= n_count;
            r_wanted   <= n_wanted;
            r_buf      <= n_buf;
            r_mapped   <= n_mapped;
            r_chars    <= n_chars;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/serial_display_frame_decoder.sv
`default_nettype none
`include "assert_macros.svh"

// Decodes a bit-banged serial display stream. Each input transaction is one
// sample of the display pins; only rising edges of the clock pin act. A pin
// sample that causes no digit words starts no burst, so such transactions
// stream at one per cycle while no burst is in progress. A rising edge with
// power enable low produces a burst of DIGITS digit words, one per cycle from
// the output register as the sink takes them, and the input is held off until
// the last word of the burst is loaded. The words are read one at a time
// through the single digit read port of the character store.
module serial_display_frame_decoder #(
    parameter int DIGITS          = 12,
    parameter int DATA_FRAME_BITS = 100
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [4:0] pin_bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [3:0] digit_index, [21:4] segment_word,
                                             // [27:22] char_code
    output logic             m_axis_tlast    // last_digit
);
    import sdfd_pkg::*;

    localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DIGITS - 1);

    logic          r_busy, n_busy;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    logic [28:0]   r_out_data, n_out_data;
    logic          r_out_last, n_out_last;

    t_frame_stat   w_stat;
    logic [7:0]    w_char;
    logic          w_accept;
    logic          w_load;
    logic [17:0]   w_seg_raw;

    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = r_busy && (!r_out_valid || m_axis_tready);

    sdfd_frame #(
        .DIGITS          (DIGITS),
        .DATA_FRAME_BITS (DATA_FRAME_BITS),
        .IW              (IW)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_pins    (s_axis_tdata[4:0]),
        .i_rd_idx  (r_idx),
        .o_stat    (w_stat),
        .o_rd_char (w_char)
    );

    assign w_seg_raw = w_stat.mapped ? {w_char[7], w_char[6], glyph(w_char[5:0])} : '0;

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_data  = {1'b1, w_char[5:0], swap_segments(w_seg_raw), 4'(r_idx)};
            n_out_last  = (r_idx == LAST_IDX);
            if (r_idx == LAST_IDX) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
        if (w_stat.emit) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_data};
    assign m_axis_tlast  = r_out_last;

    `ASSERT_IMPLY(a_no_emit_busy, i_clk, i_rst_n, r_busy, !w_stat.emit)
    `ASSERT_NEXT(a_emit_starts, i_clk, i_rst_n, w_stat.emit, r_busy && r_idx == '0)
    `ASSERT_IMPLY(a_last_match, i_clk, i_rst_n, r_out_valid,
                  r_out_last == (r_out_data[3:0] == 4'(LAST_IDX)))
    `ASSERT_ALWAYS(a_idx_range, i_clk, i_rst_n, r_idx <= LAST_IDX)

endmodule

`default_nettype wire
